// ----- hw/rtl/mm_pkg.sv -----
// mm_pkg: shared constants, types and helpers for the matrix multiply block
// used by mm_ram users, mm_ctrl, mm_datapath and matrix_multiply
package mm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;
  localparam int PROD_W = 32;

  localparam int DIM_LIMIT = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int MUL_W     = 2 * ELEM_WIDTH;
  localparam int ACC_W     = MUL_W + $clog2(MAX_DIM) + 1;
  localparam int SAT_W     = (ACC_W > PROD_W + 1) ? ACC_W : PROD_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_ROWS_A = 2'd0,
    REG_COLS_A = 2'd1,
    REG_ROWS_B = 2'd2,
    REG_COLS_B = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] cols_a;
    logic [DIM_W-1:0] rows_b;
    logic [DIM_W-1:0] cols_b;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             rd_first;
    logic             load_out;
    logic             out_last;
    logic             bad;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic [DIM_W-1:0] lim_dim(input logic [DIM_W-1:0] d);
    return (d > DIM_W'(DIM_LIMIT)) ? DIM_W'(DIM_LIMIT) : d;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
  endfunction

endpackage

// ----- hw/rtl/mm_ram.sv -----
// mm_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mm_ctrl.sv -----
// mm_ctrl: sequencer for loads and for the row, column and inner-index walk
// depends on mm_pkg
module mm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  mm_pkg::op_e     in_op_i,
  output logic            in_ready_o,
  input  mm_pkg::cfg_t    cfg_i,
  input  mm_pkg::status_t status_i,
  output mm_pkg::cmd_t    cmd_o
);
  import mm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic [DIM_W-1:0] m_q, m_d, n_q, n_d, inner_q, inner_d;
  logic             bad_q, bad_d;
  logic             wait_q, wait_d;

  logic [DIM_W-1:0] m_new, n_new, inner_new, inner_b_new;
  logic             bad_new, row_end, col_end;

  assign m_new       = lim_dim(cfg_i.rows_a);
  assign n_new       = lim_dim(cfg_i.cols_b);
  assign inner_new   = lim_dim(cfg_i.cols_a);
  assign inner_b_new = lim_dim(cfg_i.rows_b);
  assign bad_new     = (inner_new != inner_b_new) || (inner_new == '0);

  assign col_end = (DIM_W'(c_q) + DIM_W'(1)) == n_q;
  assign row_end = (DIM_W'(r_q) + DIM_W'(1)) == m_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    m_d     = m_q;
    n_d     = n_q;
    inner_d = inner_q;
    bad_d   = bad_q;
    wait_d  = wait_q;

    cmd_o          = '0;
    cmd_o.row      = r_q;
    cmd_o.col      = c_q;
    cmd_o.k        = k_q;
    cmd_o.bad      = bad_q;
    cmd_o.rd_first = (k_q == '0);
    cmd_o.out_last = row_end && col_end;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_op_i)
            OP_WRITE_A: cmd_o.wr_a = 1'b1;
            OP_WRITE_B: cmd_o.wr_b = 1'b1;
            OP_COMPUTE: begin
              m_d     = m_new;
              n_d     = n_new;
              inner_d = inner_new;
              bad_d   = bad_new;
              r_d     = '0;
              c_d     = '0;
              k_d     = '0;
              if (m_new != '0 && n_new != '0) begin
                state_d = bad_new ? ST_EMIT : ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd_o.rd_en = 1'b1;
        if ((DIM_W'(k_q) + DIM_W'(1)) == inner_q) begin
          k_d     = '0;
          wait_d  = 1'b0;
          state_d = ST_WAIT;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        // covers ram read and multiply register before the sum settles
        wait_d = 1'b1;
        if (wait_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (row_end && col_end) begin
            state_d = ST_IDLE;
          end else begin
            if (col_end) begin
              c_d = '0;
              r_d = r_q + IDX_W'(1);
            end else begin
              c_d = c_q + IDX_W'(1);
            end
            state_d = bad_q ? ST_EMIT : ST_RUN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      m_q     <= '0;
      n_q     <= '0;
      inner_q <= '0;
      bad_q   <= 1'b0;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
      m_q     <= m_d;
      n_q     <= n_d;
      inner_q <= inner_d;
      bad_q   <= bad_d;
      wait_q  <= wait_d;
    end
  end

endmodule

// ----- hw/rtl/mm_datapath.sv -----
// mm_datapath: element stores, multiply-accumulate pipe, saturation, output word
// depends on mm_pkg and mm_ram
module mm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mm_pkg::cmd_t                  cmd_i,
  output mm_pkg::status_t               status_o,
  input  logic [mm_pkg::IDX_W-1:0]      in_row_i,
  input  logic [mm_pkg::IDX_W-1:0]      in_col_i,
  input  logic [mm_pkg::ELEM_WIDTH-1:0] in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mm_pkg::IDX_W-1:0]      out_row_o,
  output logic [mm_pkg::IDX_W-1:0]      out_col_o,
  output logic [mm_pkg::PROD_W-1:0]     out_product_o,
  output logic                          out_last_o,
  output logic                          out_err_o
);
  import mm_pkg::*;

  localparam bit ROW_ALL = (MAX_DIM >= 8);
  localparam logic signed [SAT_W-1:0] P_MAX = {{(SAT_W-PROD_W+1){1'b0}}, {(PROD_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] P_MIN = {{(SAT_W-PROD_W+1){1'b1}}, {(PROD_W-1){1'b0}}};

  logic                  in_ok;
  logic [ADDR_W-1:0]     waddr, a_raddr, b_raddr;
  logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;

  logic                    rd_v_q, rd_first_q;
  logic                    mul_v_q, mul_first_q;
  logic signed [MUL_W-1:0] mul_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, mul_ext;
  logic signed [SAT_W-1:0] acc_wide;
  logic [PROD_W-1:0]       sat_val;

  logic                 out_valid_q;
  logic [IDX_W-1:0]     out_row_q, out_col_q;
  logic [PROD_W-1:0]    out_prod_q;
  logic                 out_last_q, out_err_q;

  // writes beyond the store are dropped
  assign in_ok = ROW_ALL ||
                 ((in_row_i < IDX_W'(MAX_DIM)) && (in_col_i < IDX_W'(MAX_DIM)));
  assign waddr   = elem_addr(in_row_i, in_col_i);
  assign a_raddr = elem_addr(cmd_i.row, cmd_i.k);
  assign b_raddr = elem_addr(cmd_i.k, cmd_i.col);

  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a && in_ok),
    .waddr_i (waddr),
    .wdata_i (in_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b && in_ok),
    .waddr_i (waddr),
    .wdata_i (in_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign mul_ext = {{(ACC_W-MUL_W){mul_q[MUL_W-1]}}, mul_q};
  assign acc_d   = mul_first_q ? mul_ext : acc_q + mul_ext;

  // sign-extended view of the running sum
  assign acc_wide = SAT_W'(acc_q);

  always_comb begin
    priority if (acc_wide > P_MAX) begin
      sat_val = P_MAX[PROD_W-1:0];
    end else if (acc_wide < P_MIN) begin
      sat_val = P_MIN[PROD_W-1:0];
    end else begin
      sat_val = acc_wide[PROD_W-1:0];
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_v_q  <= cmd_i.rd_en;
      mul_v_q <= rd_v_q;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_first_q <= cmd_i.rd_first;
    if (rd_v_q) begin
      mul_q       <= $signed(a_rdata) * $signed(b_rdata);
      mul_first_q <= rd_first_q;
    end
    if (mul_v_q) begin
      acc_q <= acc_d;
    end
    if (cmd_i.load_out) begin
      out_row_q  <= cmd_i.row;
      out_col_q  <= cmd_i.col;
      out_prod_q <= cmd_i.bad ? '0 : sat_val;
      out_last_q <= cmd_i.out_last;
      out_err_q  <= cmd_i.bad;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign out_product_o = out_prod_q;
  assign out_last_o    = out_last_q;
  assign out_err_o     = out_err_q;

endmodule

// ----- hw/rtl/matrix_multiply.sv -----
// matrix_multiply: top level, configuration registers and stream ports
// depends on mm_pkg, mm_ctrl, mm_datapath (and through it mm_ram)
//
// usage
//   input stream: each word is either an element write to store A or B at
//   (row, col), or a compute command. element writes are taken one per cycle
//   whenever the block is idle. a compute command starts a walk over the
//   rows_a x cols_b product in row-major order; no input word is taken until
//   the last product word has been handed to the output register.
//   output stream: one word per product element, tlast on the final one,
//   tuser set when the inner sizes differ or are zero (then product is 0).
//   configuration: cfg_we_i writes register cfg_idx_i (rows_a, cols_a,
//   rows_b, cols_b); the user must write only while the block is idle,
//   which the block itself leaves unchecked. sizes above 8 count as 8.
//   datapath: the single shared multiply-accumulate unit reads one A and
//   one B element per cycle over the inner index; the ram read and the
//   multiply are registered before each sum is ready, and the sum is then
//   loaded into the output register. with a size error no elements are
//   read and each product word goes straight to the output register.
//   stalls: the output register holds the word until m_axis_tready; the walk
//   waits on it. the next input word may be accepted while the final product
//   word still waits.
//   reset: sizes return to 8, the element stores are left as they were
//   and must be written before use.
module matrix_multiply (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [mm_pkg::DIM_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,  // operation, row, col, value
  // output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [39:0]               m_axis_tdata,  // out_row, out_col, product, zero pad
  output logic                      m_axis_tlast,
  output logic                      m_axis_tuser   // size_error
);
  import mm_pkg::*;

  // configuration registers
  logic [DIM_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  cfg_t             cfg;

  // input word fields
  op_e                   in_op;
  logic [IDX_W-1:0]      in_row, in_col;
  logic [ELEM_WIDTH-1:0] in_value;

  // output word fields
  logic [IDX_W-1:0]  out_row, out_col;
  logic [PROD_W-1:0] out_product;

  cmd_t    cmd;
  status_t status;

  assign in_op    = op_e'(s_axis_tdata[1:0]);
  assign in_row   = s_axis_tdata[4:2];
  assign in_col   = s_axis_tdata[7:5];
  assign in_value = s_axis_tdata[23:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= DIM_W'(8);
      cols_a_q <= DIM_W'(8);
      rows_b_q <= DIM_W'(8);
      cols_b_q <= DIM_W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_ROWS_A: rows_a_q <= cfg_wdata_i;
        REG_COLS_A: cols_a_q <= cfg_wdata_i;
        REG_ROWS_B: rows_b_q <= cfg_wdata_i;
        REG_COLS_B: cols_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg.rows_a = rows_a_q;
  assign cfg.cols_a = cols_a_q;
  assign cfg.rows_b = rows_b_q;
  assign cfg.cols_b = cols_b_q;

  mm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (in_op),
    .in_ready_o (s_axis_tready),
    .cfg_i      (cfg),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_row_i      (in_row),
    .in_col_i      (in_col),
    .in_value_i    (in_value),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .out_product_o (out_product),
    .out_last_o    (m_axis_tlast),
    .out_err_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, out_product, out_col, out_row};

  // a size error always carries a zero product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (out_product == '0))
    else $error("size error word with non-zero product");

  // a compute word closes the input until the walk is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (in_op == OP_COMPUTE) &&
     (lim_dim(rows_a_q) != '0) && (lim_dim(cols_b_q) != '0)) |=> !s_axis_tready)
    else $error("input accepted during a compute walk");

  // the final word sits at the bottom-right corner of the product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      ((DIM_W'(out_row) + DIM_W'(1)) == lim_dim(rows_a_q)) &&
      ((DIM_W'(out_col) + DIM_W'(1)) == lim_dim(cols_b_q)))
    else $error("last word not at final product position");

endmodule

// ----- bench/tb_matrix_multiply.sv -----
`timescale 1ns / 1ps
// tb_matrix_multiply: self-checking bench for the matrix multiply block
// feeds element writes and compute words, predicts every product word and checks the
// output stream against it; depends on mm_pkg and matrix_multiply
module tb_matrix_multiply;
  import mm_pkg::*;

  localparam int         LIMIT_CYCLES = 2_000_000;
  localparam int         SETTLE       = 16;   // settling wait at the end of a drain
  localparam int         LONG_HOLD    = 600;
  localparam int         RAND_PHASES  = 8;
  localparam int         PHASE_WORDS  = 30;
  localparam logic [1:0] OP_SPARE     = 2'd3; // unused opcode, block drops it

  typedef enum logic {ROW_SIZES, ROW_WORD} dir_kind_e;

  // one stimulus step: a size setting or an input word, optionally with a
  // product/error value typed in for every word the compute gives
  typedef struct packed {
    dir_kind_e   kind;
    cfg_t        dims;
    logic [1:0]  op;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] value;
    logic        fixed;
    logic [31:0] fixed_prod;
    logic        fixed_err;
  } dir_row_t;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] prod;
    logic        last;
    logic        err;
  } prod_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // operation, row, col, value
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // out_row, out_col, product, zero pad
  logic        m_axis_tlast;
  logic        m_axis_tuser;   // size_error

  // predictor state: element stores and current sizes
  logic signed [15:0] store_a [DEPTH];
  logic signed [15:0] store_b [DEPTH];
  cfg_t               sizes;
  prod_word_t         prod_q [$];  // product words still awaited

  int burst_left     = 0;
  int words_sent     = 0;
  int computes_sent  = 0;
  int settings_used  = 0;
  int words_checked  = 0;
  int mismatches     = 0;
  bit hold_req       = 1'b0;

  matrix_multiply dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // small helpers for building stimulus
  // ---------------------------------------------------------------------

  function automatic dir_row_t dims_row(input int ra, input int ca, input int rb, input int cb);
    dir_row_t d;
    d             = '0;
    d.kind        = ROW_SIZES;
    d.dims.rows_a = 4'(ra);
    d.dims.cols_a = 4'(ca);
    d.dims.rows_b = 4'(rb);
    d.dims.cols_b = 4'(cb);
    return d;
  endfunction

  function automatic dir_row_t word_row(input logic [1:0] op, input int row, input int col,
                                        input logic [15:0] value);
    dir_row_t d;
    d       = '0;
    d.kind  = ROW_WORD;
    d.op    = op;
    d.row   = 3'(row);
    d.col   = 3'(col);
    d.value = value;
    return d;
  endfunction

  // compute word whose product and error flag are known up front
  function automatic dir_row_t fixed_row(input logic [31:0] prod, input logic err);
    dir_row_t d;
    d            = word_row(OP_COMPUTE, 0, 0, 16'h0000);
    d.fixed      = 1'b1;
    d.fixed_prod = prod;
    d.fixed_err  = err;
    return d;
  endfunction

  // register values above the index reach count as the largest size
  function automatic int clip_dim(input logic [3:0] d);
    return (int'(d) > DIM_LIMIT) ? DIM_LIMIT : int'(d);
  endfunction

  function automatic logic [3:0] rand_dim();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1:       return 4'($urandom_range(9, 15));
      2:       return 4'd8;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // mix of extremes, small magnitudes and full-range values
  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      4, 5, 6: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly inside the configured sizes so the writes matter, else anywhere
  function automatic int pick_idx(input int span);
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, span - 1) : $urandom_range(0, 7);
  endfunction

  // ---------------------------------------------------------------------
  // sender: bursts of words with random gaps, prediction at acceptance
  // ---------------------------------------------------------------------

  task automatic send_word(input dir_row_t w);
    int         gap;
    int         m;
    int         n;
    int         inner;
    int         inner_b;
    bit         bad;
    longint     acc;
    prod_word_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.value, w.col, w.row, w.op};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;

    case (w.op)
      OP_WRITE_A: store_a[int'(w.row) * MAX_DIM + int'(w.col)] = w.value;
      OP_WRITE_B: store_b[int'(w.row) * MAX_DIM + int'(w.col)] = w.value;
      OP_COMPUTE: begin
        computes_sent++;
        m       = clip_dim(sizes.rows_a);
        inner   = clip_dim(sizes.cols_a);
        inner_b = clip_dim(sizes.rows_b);
        n       = clip_dim(sizes.cols_b);
        bad     = (inner != inner_b) || (inner == 0);
        // row-major walk over the product, exact sum then 32-bit saturation
        for (int r = 0; r < m; r++) begin
          for (int c = 0; c < n; c++) begin
            acc = 0;
            if (!bad) begin
              for (int k = 0; k < inner; k++) begin
                acc += longint'(store_a[r * MAX_DIM + k]) * longint'(store_b[k * MAX_DIM + c]);
              end
            end
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            p.row  = 3'(r);
            p.col  = 3'(c);
            p.prod = bad ? 32'h0 : acc[31:0];
            p.last = (r == m - 1) && (c == n - 1);
            p.err  = bad;
            if (w.fixed) begin
              p.prod = w.fixed_prod;
              p.err  = w.fixed_err;
            end
            prod_q.push_back(p);
          end
        end
      end
      default: ;  // spare opcode: nothing stored, nothing emitted
    endcase
  endtask

  // size registers are only touched with the block idle
  task automatic set_sizes(input cfg_t d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_ROWS_A;
    cfg_wdata_i <= d.rows_a;
    @(posedge clk_i);
    cfg_idx_i   <= REG_COLS_A;
    cfg_wdata_i <= d.cols_a;
    @(posedge clk_i);
    cfg_idx_i   <= REG_ROWS_B;
    cfg_wdata_i <= d.rows_b;
    @(posedge clk_i);
    cfg_idx_i   <= REG_COLS_B;
    cfg_wdata_i <= d.cols_b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sizes = d;
    settings_used++;
  endtask

  // stop offering, wait for every awaited word, then let the block settle
  // (a compute with zero rows or columns gives no words and starts no walk)
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (prod_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // receiver: stall pattern of its own, plus one long hold-off on request
  // ---------------------------------------------------------------------

  initial begin
    int mode;
    int left;
    int hold;
    mode = 0;
    left = 0;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(10, 80);
        end
        left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // checker: every accepted product word against the oldest expectation
  // ---------------------------------------------------------------------

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : product_check
    prod_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (prod_q.size() == 0) begin
        $display("%0t: unexpected product word row %0d col %0d value %h", $time,
                 m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[37:6]);
        mismatches++;
      end else begin
        want = prod_q.pop_front();
        words_checked++;
        check_field("out_row", 32'(want.row), 32'(m_axis_tdata[2:0]));
        check_field("out_col", 32'(want.col), 32'(m_axis_tdata[5:3]));
        check_field("product", want.prod, m_axis_tdata[37:6]);
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
        check_field("size_error", 32'(want.err), 32'(m_axis_tuser));
      end
    end
  end

  // ---------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d product words still awaited",
             cycle_count, prod_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  initial begin
    dir_row_t dir_tab [$];
    cfg_t     dims;
    int       span;
    int       pick;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_ROWS_A;
    cfg_wdata_i   <= 4'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 24'h0;
    sizes = {4'd8, 4'd8, 4'd8, 4'd8};

    dir_tab = {
      // reset sizes, full 8x8x8 product over the filled stores
      word_row(OP_COMPUTE, 0, 0, 16'h0000),
      // two products of -128.0 * -128.0 overflow upwards
      dims_row(1, 2, 2, 1),
      word_row(OP_WRITE_A, 0, 0, 16'h8000),
      word_row(OP_WRITE_A, 0, 1, 16'h8000),
      word_row(OP_WRITE_B, 0, 0, 16'h8000),
      word_row(OP_WRITE_B, 1, 0, 16'h8000),
      fixed_row(32'h7FFF_FFFF, 1'b0),
      // three of -128.0 * ~128.0 overflow downwards
      dims_row(1, 3, 3, 1),
      word_row(OP_WRITE_A, 0, 2, 16'h8000),
      word_row(OP_WRITE_B, 0, 0, 16'h7FFF),
      word_row(OP_WRITE_B, 1, 0, 16'h7FFF),
      word_row(OP_WRITE_B, 2, 0, 16'h7FFF),
      fixed_row(32'h8000_0000, 1'b0),
      // 1.0 times 1.0 is 1.0 in q16.16
      dims_row(1, 1, 1, 1),
      word_row(OP_WRITE_A, 0, 0, 16'h0100),
      word_row(OP_WRITE_B, 0, 0, 16'h0100),
      fixed_row(32'h0001_0000, 1'b0),
      // far corners lie outside the sizes but are still stored
      word_row(OP_WRITE_A, 7, 7, 16'h7FFF),
      word_row(OP_WRITE_B, 7, 7, 16'hFFFF),
      // spare opcode with every write field set is dropped
      word_row(OP_SPARE, 7, 7, 16'hFFFF),
      // inner sizes differ: all zero, error flagged
      dims_row(8, 8, 7, 8),
      fixed_row(32'h0, 1'b1),
      // inner size zero: same
      dims_row(2, 0, 0, 3),
      fixed_row(32'h0, 1'b1),
      // no rows: no words at all
      dims_row(0, 4, 4, 5),
      word_row(OP_COMPUTE, 0, 0, 16'h0000),
      // sizes above eight count as eight; write fields of a compute ignored
      dims_row(15, 15, 15, 15),
      word_row(OP_COMPUTE, 7, 7, 16'hFFFF)
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stores are undefined after reset, so every entry is written first
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int c = 0; c < MAX_DIM; c++) begin
        send_word(word_row(OP_WRITE_A, r, c, rand_value()));
        send_word(word_row(OP_WRITE_B, r, c, rand_value()));
      end
    end

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_SIZES) begin
        drain();
        set_sizes(dir_tab[i].dims);
      end else begin
        send_word(dir_tab[i]);
      end
    end

    // random phases, each under its own size setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       dims = {4'd8, 4'd8, 4'd8, 4'd8};
        1:       dims = {4'd1, 4'd1, 4'd1, 4'd1};
        default: begin
          dims.rows_a = rand_dim();
          dims.cols_a = rand_dim();
          dims.rows_b = ($urandom_range(0, 5) == 0) ? rand_dim() : dims.cols_a;
          dims.cols_b = rand_dim();
        end
      endcase
      drain();
      set_sizes(dims);
      span = clip_dim(dims.rows_a);
      if (clip_dim(dims.cols_a) > span) span = clip_dim(dims.cols_a);
      if (clip_dim(dims.rows_b) > span) span = clip_dim(dims.rows_b);
      if (clip_dim(dims.cols_b) > span) span = clip_dim(dims.cols_b);
      if (span == 0) span = MAX_DIM;

      if (ph == 0) begin
        // long output hold-off over a full-size product: the block fills
        // up and stops taking words while the sender keeps offering
        send_word(word_row(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                           16'($urandom)));
        hold_req = 1'b1;
      end

      for (int i = 0; i < PHASE_WORDS; ) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_word(word_row(OP_SPARE, $urandom_range(0, 7), $urandom_range(0, 7),
                             16'($urandom)));
        end else begin
          i++;
          if (pick < 14)
            send_word(word_row(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                               16'($urandom)));
          else if (pick < 57)
            send_word(word_row(OP_WRITE_A, pick_idx(span), pick_idx(span), rand_value()));
          else
            send_word(word_row(OP_WRITE_B, pick_idx(span), pick_idx(span), rand_value()));
        end
      end
    end

    drain();
    $display("covered %0d input words, %0d of them compute words, over %0d size settings",
             words_sent, computes_sent, settings_used);
    $display("%0d product words compared, %0d field mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- matrix_multiply.f -----
hw/rtl/mm_pkg.sv
hw/rtl/mm_ram.sv
hw/rtl/mm_ctrl.sv
hw/rtl/mm_datapath.sv
hw/rtl/matrix_multiply.sv
bench/tb_matrix_multiply.sv
